// ===== hw/rtl/kpq_pkg.sv =====
`timescale 1ns / 1ps

package kpq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned OccW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // sort key: priority, then pages, then id; compared as one unsigned vector
  typedef struct packed {
    logic [15:0] prio;
    logic [8:0]  pages;
    logic [15:0] id;
  } key_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] job_id;
    logic [8:0]  page_count;
    logic [15:0] priority_req;
  } in_beat_t;

  typedef struct packed {
    logic          popped_valid;
    logic [15:0]   popped_id;
    logic [8:0]    popped_pages;
    logic [15:0]   popped_priority;
    status_e       status;
    logic [OccW-1:0] occupancy;
  } out_beat_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } ctrl_t;

endpackage

// ===== hw/rtl/kpq_cell.sv =====
`timescale 1ns / 1ps

module kpq_cell (
  input  logic          clk_i,
  input  kpq_pkg::ctrl_t ctrl_i,
  input  kpq_pkg::key_t key_i,
  input  logic          occ_i,
  input  logic          left_le_i,
  input  kpq_pkg::key_t left_entry_i,
  input  kpq_pkg::key_t right_entry_i,
  output logic          le_o,
  output kpq_pkg::key_t entry_o
);
  import kpq_pkg::*;

  key_t entry_q;
  key_t entry_d;

  // entries at or below the new key stay put; the rest shift right
  assign le_o = occ_i && (entry_q <= key_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !le_o) begin
      entry_d = left_le_i ? key_i : left_entry_i;
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/keyed_priority_queue_top.sv =====
`timescale 1ns / 1ps
// An accepted beat's result beat is registered and is shown in the cycle after acceptance.
// Throughput: one beat per cycle while the output is not stalled; each cell does one key compare per op.
// Reset clears the job count and the output valid; entry storage has no
// reset and is only read below the count.
module keyed_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = kpq_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kpq_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kpq_pkg::out_beat_t out_beat_o
);
  import kpq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_beat_q, res;
  ctrl_t           ctrl;
  key_t            new_key;
  logic            accept, full, empty;

  key_t entry_w [QUEUE_DEPTH];
  logic le_w    [QUEUE_DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty      = (cnt_q == '0);

  assign new_key.prio  = in_beat_i.priority_req;
  assign new_key.pages = in_beat_i.page_count;
  assign new_key.id    = in_beat_i.job_id;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    kpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (new_key),
      .occ_i        (cnt_q > CntW'(g)),
      .left_le_i    ((g == 0) ? 1'b1 : le_w[(g == 0) ? 0 : g - 1]),
      .left_entry_i (entry_w[(g == 0) ? 0 : g - 1]),
      .right_entry_i(entry_w[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
      .le_o         (le_w[g]),
      .entry_o      (entry_w[g])
    );
  end

  always_comb begin
    ctrl  = '0;
    cnt_d = cnt_q;
    res   = '0;
    res.status = ST_OK;
    if (accept) begin
      unique case (in_beat_i.op)
        OP_INSERT: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end
        end
        OP_POP: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            ctrl.pop            = 1'b1;
            cnt_d               = cnt_q - 1'b1;
            res.popped_valid    = 1'b1;
            res.popped_id       = entry_w[0].id;
            res.popped_pages    = entry_w[0].pages;
            res.popped_priority = entry_w[0].prio;
          end
        end
        OP_CLEAR: cnt_d = '0;
        default: ;
      endcase
    end
    res.occupancy = OccW'(cnt_d);
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("job count above depth");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_beat_i.op == OP_POP && !empty) |=> out_beat_o.popped_valid)
    else $error("pop on nonempty queue returned no job");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > CntW'(1)) |-> (entry_w[0] <= entry_w[1]))
    else $error("head cells out of order");

endmodule
